@@ hdl/mce_pkg.sv @@
package mce_pkg;

    localparam int KEYS         = 128;
    localparam int CHANNELS_DEF = 16;
    localparam int STEPS        = 10;

    // status high nibble of the note messages that get expanded
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_POLY     = 4'hA;

    // configuration register indexes
    localparam logic [1:0] CFG_CHANNEL_FILTER = 2'd0;
    localparam logic [1:0] CFG_SCALE_ROOT     = 2'd1;
    localparam logic [1:0] CFG_CHORD_MASK     = 2'd2;

    localparam logic [9:0] CHORD_MASK_RESET = 10'd39;
    localparam logic [4:0] FILTER_MAX       = 5'd16;
    localparam logic [4:0] FILTER_CLAMP     = 5'd15;
    localparam logic [3:0] ROOT_MAX         = 4'd11;
    localparam logic [7:0] COUNT_MAX        = 8'd255;

    // bit d set: degree d of the major scale is on the scale
    localparam logic [11:0] ON_SCALE = 12'b1010_1011_0101;

    typedef logic signed [5:0] interval_t;

    // interval in semitones, by scale degree and chord mask bit
    localparam interval_t INTERVALS [12][10] = '{
        '{6'sd0, 6'sd4, 6'sd7, 6'sd9, 6'sd11, 6'sd12, 6'sd14, 6'sd17, 6'sd21, -6'sd12},
        '{6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0,  6'sd0,  6'sd0,  6'sd0,  6'sd0,  6'sd0},
        '{6'sd0, 6'sd3, 6'sd7, 6'sd9, 6'sd10, 6'sd12, 6'sd14, 6'sd17, 6'sd21, -6'sd12},
        '{6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0,  6'sd0,  6'sd0,  6'sd0,  6'sd0,  6'sd0},
        '{6'sd0, 6'sd3, 6'sd7, 6'sd8, 6'sd10, 6'sd12, 6'sd13, 6'sd17, 6'sd20, -6'sd12},
        '{6'sd0, 6'sd4, 6'sd7, 6'sd9, 6'sd11, 6'sd12, 6'sd14, 6'sd18, 6'sd21, -6'sd12},
        '{6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0,  6'sd0,  6'sd0,  6'sd0,  6'sd0,  6'sd0},
        '{6'sd0, 6'sd4, 6'sd7, 6'sd9, 6'sd10, 6'sd12, 6'sd14, 6'sd17, 6'sd21, -6'sd12},
        '{6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0,  6'sd0,  6'sd0,  6'sd0,  6'sd0,  6'sd0},
        '{6'sd0, 6'sd3, 6'sd7, 6'sd8, 6'sd10, 6'sd12, 6'sd14, 6'sd17, 6'sd20, -6'sd12},
        '{6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0,  6'sd0,  6'sd0,  6'sd0,  6'sd0,  6'sd0},
        '{6'sd0, 6'sd3, 6'sd6, 6'sd8, 6'sd10, 6'sd12, 6'sd13, 6'sd16, 6'sd19, -6'sd12}
    };

    typedef struct packed {
        logic [7:0]  status;
        logic [7:0]  data_one;
        logic [7:0]  data_two;
        logic [1:0]  length;
        logic [15:0] stamp;
    } result_t;

endpackage

@@ hdl/mce_if.sv @@
interface mce_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  status_byte;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [1:0]  msg_length;
    logic [15:0] event_time;

    modport source (output valid, status_byte, data_one, data_two, msg_length, event_time,
                    input ready);
    modport sink   (input valid, status_byte, data_one, data_two, msg_length, event_time,
                    output ready);
endinterface

interface mce_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_status;
    logic [7:0]  out_data_one;
    logic [7:0]  out_data_two;
    logic [1:0]  out_length;
    logic [15:0] out_time;
    logic        is_last;

    modport source (output valid, out_status, out_data_one, out_data_two, out_length,
                    out_time, is_last, input ready);
    modport sink   (input valid, out_status, out_data_one, out_data_two, out_length,
                    out_time, is_last, output ready);
endinterface

interface mce_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/mce_ram.sv @@
module mce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
)(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

@@ hdl/midi_chord_expander.sv @@
// Channel  Role    Beat contents
// msg_in   sink    status_byte, data_one, data_two, msg_length, event_time
// msg_out  source  out_status, out_data_one, out_data_two, out_length, out_time, is_last
// cfg      sink    index (0 channel_filter, 1 scale_root, 2 chord_mask), data
//
// Sequencing: pass-through beats go straight to flush; note-on/off/poly walk
//   the chord steps in turn through the single shared interval adder, plus a
//   held-count update per on/off note (note-off first looks up the chord).
// Reset: a clearing pass over all CHANNELS*128 addresses (2048 by default)
//   zeroes both memories; msg_in stays not ready meanwhile, cfg is always ready.
// Stalls: msg_in is ready only between items; results wait in a pending stage
//   and an output register, so a back-pressured msg_out stalls any emitting step.
module midi_chord_expander #(
    parameter int CHANNELS = mce_pkg::CHANNELS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    mce_in_if.sink     msg_in,
    mce_out_if.source  msg_out,
    mce_cfg_if.sink    cfg
);
    import mce_pkg::*;

    localparam int DEPTH  = CHANNELS * KEYS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [3:0]        LAST_STEP = 4'(STEPS - 1);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b000_0001,
        S_IDLE   = 7'b000_0010,
        S_DECODE = 7'b000_0100,
        S_CHECK  = 7'b000_1000,
        S_STEP   = 7'b001_0000,
        S_COUNT  = 7'b010_0000,
        S_FLUSH  = 7'b100_0000
    } state_t;

    // control
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [4:0]        filter_reg, filter_next;
    logic [3:0]        root_reg, root_next;
    logic [9:0]        mask_reg, mask_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              out_valid_reg, out_valid_next;

    // item payload
    logic [3:0]  kind_reg, kind_next;
    logic [3:0]  chn_reg, chn_next;
    logic [6:0]  key_reg, key_next;
    logic [7:0]  val_reg, val_next;
    logic [15:0] stamp_reg, stamp_next;
    logic [7:0]  deg_arg_reg, deg_arg_next;
    logic [3:0]  deg_reg, deg_next;
    logic [9:0]  chord_reg, chord_next;
    logic [3:0]  step_reg, step_next;
    logic [6:0]  note_reg, note_next;
    result_t     pend_reg, pend_next;
    result_t     out_reg, out_next;
    logic        out_last_reg, out_last_next;

    // memory ports
    logic              chord_wr_en, chord_rd_en;
    logic [ADDR_W-1:0] chord_wr_addr, chord_rd_addr;
    logic [10:0]       chord_wr_data, chord_rd_data;
    logic              count_wr_en, count_rd_en;
    logic [ADDR_W-1:0] count_wr_addr, count_rd_addr;
    logic [7:0]        count_wr_data, count_rd_data;

    // decode of the incoming beat
    logic [3:0]  in_kind, in_chn, root_clamp;
    logic [4:0]  filter_want;
    logic        chan_ok, chn_in_range, note_kind, expand;

    // degree = (key + 12 - root) mod 12 by reciprocal multiply
    logic [15:0] deg_prod;
    logic [4:0]  deg_quot;
    logic [7:0]  deg_rem;

    // shared interval adder
    interval_t   interval;
    logic [8:0]  note_sum;
    logic        note_ok;
    logic [ADDR_W-1:0] slot;

    logic        out_free, can_emit, step_done;
    state_t      adv_state;
    logic [3:0]  step_adv;
    result_t     new_result;
    logic [7:0]  count_new;
    logic        count_emit, count_change;

    mce_ram #(.WIDTH(11), .DEPTH(DEPTH)) u_chord_ram (
        .clk     (clk),
        .wr_en   (chord_wr_en),
        .wr_addr (chord_wr_addr),
        .wr_data (chord_wr_data),
        .rd_en   (chord_rd_en),
        .rd_addr (chord_rd_addr),
        .rd_data (chord_rd_data)
    );

    mce_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_count_ram (
        .clk     (clk),
        .wr_en   (count_wr_en),
        .wr_addr (count_wr_addr),
        .wr_data (count_wr_data),
        .rd_en   (count_rd_en),
        .rd_addr (count_rd_addr),
        .rd_data (count_rd_data)
    );

    assign in_kind      = msg_in.status_byte[7:4];
    assign in_chn       = msg_in.status_byte[3:0];
    // out-of-range filter settings fold onto channel 15
    assign filter_want  = (filter_reg > FILTER_MAX) ? FILTER_CLAMP : filter_reg - 5'd1;
    assign chan_ok      = (filter_reg == 5'd0) || (filter_want == {1'b0, in_chn});
    assign chn_in_range = ({1'b0, in_chn} < 5'(CHANNELS));
    assign note_kind    = (in_kind == KIND_NOTE_ON) || (in_kind == KIND_NOTE_OFF)
                          || (in_kind == KIND_POLY);
    assign expand       = (msg_in.msg_length == 2'd3) && note_kind && chan_ok && chn_in_range;
    assign root_clamp   = (root_reg > ROOT_MAX) ? ROOT_MAX : root_reg;

    // 171/2048 is exact for values below 256
    assign deg_prod = 16'(deg_arg_reg) * 16'd171;
    assign deg_quot = deg_prod[15:11];
    assign deg_rem  = deg_arg_reg - 8'({3'b000, deg_quot} * 8'd12);

    assign interval = INTERVALS[deg_reg][step_reg];
    assign note_sum = {2'b00, key_reg} + {{3{interval[5]}}, interval};
    assign note_ok  = ~note_sum[8] & ~note_sum[7];
    assign slot     = ADDR_W'({chn_reg, key_reg});

    assign out_free  = ~out_valid_reg | msg_out.ready;
    assign can_emit  = ~pend_valid_reg | out_free;
    assign step_done = (step_reg == LAST_STEP);
    assign adv_state = step_done ? S_FLUSH : S_STEP;
    assign step_adv  = step_reg + 4'd1;

    always_comb
    begin
        new_result.status   = {kind_reg, chn_reg};
        new_result.data_one = {1'b0, (state_reg == S_COUNT) ? note_reg : note_sum[6:0]};
        new_result.data_two = val_reg;
        new_result.length   = 2'd3;
        new_result.stamp    = stamp_reg;
    end

    // saturating count update
    always_comb
    begin
        count_new    = count_rd_data;
        count_emit   = 1'b0;
        count_change = 1'b0;
        if (kind_reg == KIND_NOTE_ON)
        begin
            count_new    = (count_rd_data == COUNT_MAX) ? count_rd_data : count_rd_data + 8'd1;
            count_emit   = (count_new == 8'd1);
            count_change = 1'b1;
        end
        else if (count_rd_data != 8'd0)
        begin
            count_new    = count_rd_data - 8'd1;
            count_emit   = (count_new == 8'd0);
            count_change = 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        filter_next     = filter_reg;
        root_next       = root_reg;
        mask_next       = mask_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg & ~msg_out.ready;
        kind_next       = kind_reg;
        chn_next        = chn_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        stamp_next      = stamp_reg;
        deg_arg_next    = deg_arg_reg;
        deg_next        = deg_reg;
        chord_next      = chord_reg;
        step_next       = step_reg;
        note_next       = note_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;

        chord_wr_en   = 1'b0;
        chord_wr_addr = slot;
        chord_wr_data = 11'd0;
        chord_rd_en   = 1'b0;
        chord_rd_addr = slot;
        count_wr_en   = 1'b0;
        count_wr_addr = ADDR_W'({chn_reg, note_reg});
        count_wr_data = count_new;
        count_rd_en   = 1'b0;
        count_rd_addr = ADDR_W'({chn_reg, note_sum[6:0]});

        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CHANNEL_FILTER: filter_next = cfg.data[4:0];
                CFG_SCALE_ROOT:     root_next   = cfg.data[3:0];
                CFG_CHORD_MASK:     mask_next   = cfg.data;
                default:            ;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                chord_wr_en   = 1'b1;
                chord_wr_addr = clr_addr_reg;
                count_wr_en   = 1'b1;
                count_wr_addr = clr_addr_reg;
                count_wr_data = 8'd0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (msg_in.valid)
                begin
                    if (expand)
                    begin
                        kind_next    = in_kind;
                        chn_next     = in_chn;
                        key_next     = msg_in.data_one[6:0];
                        val_next     = (in_kind == KIND_POLY) ? msg_in.data_two
                                                              : {1'b0, msg_in.data_two[6:0]};
                        stamp_next   = msg_in.event_time;
                        deg_arg_next = {1'b0, msg_in.data_one[6:0]} + 8'd12 - {4'b0000, root_clamp};
                        state_next   = S_DECODE;
                    end
                    else
                    begin
                        // pass-through, unused bytes zeroed
                        pend_next.status   = msg_in.status_byte;
                        pend_next.data_one = (msg_in.msg_length >= 2'd2) ? msg_in.data_one : 8'd0;
                        pend_next.data_two = (msg_in.msg_length == 2'd3) ? msg_in.data_two : 8'd0;
                        pend_next.length   = msg_in.msg_length;
                        pend_next.stamp    = msg_in.event_time;
                        pend_valid_next    = 1'b1;
                        state_next         = S_FLUSH;
                    end
                end
            end

            S_DECODE:
            begin
                deg_next   = deg_rem[3:0];
                chord_next = ON_SCALE[deg_rem[3:0]] ? mask_reg : 10'd1;
                step_next  = 4'd0;
                case (kind_reg)
                    KIND_NOTE_OFF:
                    begin
                        chord_rd_en = 1'b1;
                        state_next  = S_CHECK;
                    end
                    KIND_NOTE_ON:
                    begin
                        chord_wr_en   = 1'b1;
                        chord_wr_data = {1'b1, ON_SCALE[deg_rem[3:0]] ? mask_reg : 10'd1};
                        state_next    = S_STEP;
                    end
                    default:
                    begin
                        state_next = S_STEP;
                    end
                endcase
            end

            S_CHECK:
            begin
                // no chord held: nothing to release
                if (chord_rd_data[10])
                begin
                    chord_next  = chord_rd_data[9:0];
                    chord_wr_en = 1'b1;
                    state_next  = S_STEP;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end

            S_STEP:
            begin
                if (chord_reg[step_reg] && note_ok)
                begin
                    if (kind_reg == KIND_POLY)
                    begin
                        if (can_emit)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_next       = pend_reg;
                                out_last_next  = 1'b0;
                                out_valid_next = 1'b1;
                            end
                            pend_next       = new_result;
                            pend_valid_next = 1'b1;
                            step_next       = step_adv;
                            state_next      = adv_state;
                        end
                    end
                    else
                    begin
                        count_rd_en = 1'b1;
                        note_next   = note_sum[6:0];
                        state_next  = S_COUNT;
                    end
                end
                else
                begin
                    step_next  = step_adv;
                    state_next = adv_state;
                end
            end

            S_COUNT:
            begin
                if (!count_emit || can_emit)
                begin
                    count_wr_en = count_change;
                    if (count_emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = new_result;
                        pend_valid_next = 1'b1;
                    end
                    step_next  = step_adv;
                    state_next = adv_state;
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            filter_reg     <= 5'd0;
            root_reg       <= 4'd0;
            mask_reg       <= CHORD_MASK_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            filter_reg     <= filter_next;
            root_reg       <= root_next;
            mask_reg       <= mask_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        chn_reg      <= chn_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        stamp_reg    <= stamp_next;
        deg_arg_reg  <= deg_arg_next;
        deg_reg      <= deg_next;
        chord_reg    <= chord_next;
        step_reg     <= step_next;
        note_reg     <= note_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign msg_in.ready         = (state_reg == S_IDLE);
    assign cfg.ready            = 1'b1;
    assign msg_out.valid        = out_valid_reg;
    assign msg_out.out_status   = out_reg.status;
    assign msg_out.out_data_one = out_reg.data_one;
    assign msg_out.out_data_two = out_reg.data_two;
    assign msg_out.out_length   = out_reg.length;
    assign msg_out.out_time     = out_reg.stamp;
    assign msg_out.is_last      = out_last_reg;
endmodule
